[hw/rtl/i8dp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8dp_pkg
// shared types and constants of the int8 quantized dot product
// ----------------------------------------------------------------------------
package i8dp_pkg;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_INVERSE_SCALE = 8'd0,
        CFG_SCALE_SQUARED = 8'd1
    } cfg_index_t;

    localparam logic [15:0] INVERSE_SCALE_RESET = 16'd32821;
    localparam logic [31:0] SCALE_SQUARED_RESET = 32'd261306;

    // one quantized pair waiting for the multiply-accumulate
    typedef struct packed {
        logic signed [7:0] act_q;
        logic signed [7:0] wgt_q;
        logic              last;
    } qentry_t;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } qstatus_t;

endpackage

[hw/rtl/i8dp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8dp_front
// takes input items, quantizes activation and weight to int8, feeds the queue
// ----------------------------------------------------------------------------
module i8dp_front
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [31:0]       activation_value,
    input  logic signed [31:0]       weight_value,
    input  logic                     last_term,
    input  logic [15:0]              inverse_scale,
    input  i8dp_pkg::qstatus_t       q_status,
    output logic                     q_push,
    output i8dp_pkg::qentry_t        q_din
);
    import i8dp_pkg::*;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic signed [31:0] s1_act_reg;
    logic signed [31:0] s1_wgt_reg;
    logic               s1_last_reg;
    logic               take;

    // q16.16 times q8.8, round half away from zero, clamp to int8
    function automatic logic signed [7:0] quantize(input logic [31:0] v, input logic [15:0] inv);
        logic        neg;
        logic [31:0] mag;
        logic [47:0] prod;
        logic [48:0] rnd;
        logic [24:0] r;
        logic [7:0]  q;
        neg  = v[31];
        mag  = neg ? (~v + 32'd1) : v;
        prod = {16'd0, mag} * {32'd0, inv};
        rnd  = {1'b0, prod} + 49'd8388608;
        r    = rnd[48:24];
        if (neg)
        begin
            q = (r > 25'd128) ? 8'h80 : (~r[7:0] + 8'd1);
        end
        else
        begin
            q = (r > 25'd127) ? 8'h7f : r[7:0];
        end
        return $signed(q);
    endfunction

    assign in_stall = s1_valid_reg && q_status.full;
    assign q_push   = s1_valid_reg && !q_status.full;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        q_din.act_q = quantize(s1_act_reg, inverse_scale);
        q_din.wgt_q = quantize(s1_wgt_reg, inverse_scale);
        q_din.last  = s1_last_reg;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_act_reg  <= activation_value;
            s1_wgt_reg  <= weight_value;
            s1_last_reg <= last_term;
        end
    end

endmodule

[hw/rtl/i8dp_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8dp_fifo
// short queue of quantized pairs between front and back
// ----------------------------------------------------------------------------
module i8dp_fifo
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  i8dp_pkg::qentry_t    din,
    input  logic                 pop,
    output i8dp_pkg::qentry_t    dout,
    output i8dp_pkg::qstatus_t   status
);
    import i8dp_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    qentry_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign dout         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

[hw/rtl/i8dp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8dp_back
// int8 multiply, saturating accumulate, rescale of the final sum
// ----------------------------------------------------------------------------
module i8dp_back
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  i8dp_pkg::qstatus_t       q_status,
    input  i8dp_pkg::qentry_t        q_dout,
    output logic                     q_pop,
    input  logic [31:0]              scale_squared,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [23:0]       integer_sum,
    output logic signed [31:0]       rescaled_sum,
    output logic                     saturated
);
    import i8dp_pkg::*;

    localparam logic [23:0] ACC_MAX = 24'h7fffff;
    localparam logic [23:0] ACC_MIN = 24'h800000;

    // product stage
    logic               p_valid_reg;
    logic               p_valid_next;
    logic signed [15:0] p_prod_reg;
    logic               p_last_reg;
    // accumulator
    logic [23:0]        acc_reg;
    logic [23:0]        acc_next;
    logic               clip_reg;
    logic               clip_next;
    // final sum stage
    logic               s_valid_reg;
    logic               s_valid_next;
    logic [23:0]        s_sum_reg;
    logic               s_clip_reg;
    // rescale multiply stage
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [55:0]        m_prod_reg;
    logic               m_neg_reg;
    logic [23:0]        m_sum_reg;
    logic               m_clip_reg;
    // output stage
    logic               o_valid_reg;
    logic               o_valid_next;
    logic [23:0]        o_sum_reg;
    logic [31:0]        o_scaled_reg;
    logic               o_clip_reg;

    logic               o_free;
    logic               m_free;
    logic               s_free;
    logic               p_take;
    logic               p_free;
    logic               m_load;
    logic               o_load;
    logic signed [15:0] prod_in;
    logic [24:0]        sum25;
    logic               ovf;
    logic [23:0]        acc_sat;
    logic [23:0]        s_mag;
    logic [56:0]        rnd;
    logic [40:0]        r;
    logic [31:0]        scaled;

    assign o_free = !o_valid_reg || !out_stall;
    assign m_free = !m_valid_reg || o_free;
    assign s_free = !s_valid_reg || m_free;
    // only the last item needs room further down
    assign p_take = p_valid_reg && (!p_last_reg || s_free);
    assign p_free = !p_valid_reg || p_take;
    assign q_pop  = !q_status.empty && p_free;
    assign m_load = s_valid_reg && m_free;
    assign o_load = m_valid_reg && o_free;

    assign prod_in = $signed(q_dout.act_q) * $signed(q_dout.wgt_q);

    always_comb
    begin
        sum25   = {acc_reg[23], acc_reg} + {{9{p_prod_reg[15]}}, p_prod_reg};
        ovf     = sum25[24] != sum25[23];
        acc_sat = ovf ? (sum25[24] ? ACC_MIN : ACC_MAX) : sum25[23:0];
    end

    always_comb
    begin
        acc_next  = acc_reg;
        clip_next = clip_reg;
        if (p_take)
        begin
            if (p_last_reg)
            begin
                acc_next  = '0;
                clip_next = 1'b0;
            end
            else
            begin
                acc_next  = acc_sat;
                clip_next = clip_reg | ovf;
            end
        end
    end

    assign s_mag = s_sum_reg[23] ? (~s_sum_reg + 24'd1) : s_sum_reg;

    // q.32 product to q16.16, half away from zero, saturate
    always_comb
    begin
        rnd = {1'b0, m_prod_reg} + 57'd32768;
        r   = rnd[56:16];
        if (m_neg_reg)
        begin
            scaled = (r > 41'h0080000000) ? 32'h80000000 : (~r[31:0] + 32'd1);
        end
        else
        begin
            scaled = (r > 41'h007fffffff) ? 32'h7fffffff : r[31:0];
        end
    end

    always_comb
    begin
        p_valid_next = q_pop ? 1'b1 : (p_take ? 1'b0 : p_valid_reg);
        s_valid_next = (p_take && p_last_reg) ? 1'b1 : (m_load ? 1'b0 : s_valid_reg);
        m_valid_next = m_load ? 1'b1 : (o_load ? 1'b0 : m_valid_reg);
        o_valid_next = o_load ? 1'b1 : ((o_valid_reg && !out_stall) ? 1'b0 : o_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            acc_reg     <= '0;
            clip_reg    <= 1'b0;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
            s_valid_reg <= s_valid_next;
            m_valid_reg <= m_valid_next;
            o_valid_reg <= o_valid_next;
            acc_reg     <= acc_next;
            clip_reg    <= clip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            p_prod_reg <= prod_in;
            p_last_reg <= q_dout.last;
        end
        if (p_take && p_last_reg)
        begin
            s_sum_reg  <= acc_sat;
            s_clip_reg <= clip_reg | ovf;
        end
        if (m_load)
        begin
            m_prod_reg <= {32'd0, s_mag} * {24'd0, scale_squared};
            m_neg_reg  <= s_sum_reg[23];
            m_sum_reg  <= s_sum_reg;
            m_clip_reg <= s_clip_reg;
        end
        if (o_load)
        begin
            o_sum_reg    <= m_sum_reg;
            o_scaled_reg <= scaled;
            o_clip_reg   <= m_clip_reg;
        end
    end

    assign out_valid    = o_valid_reg;
    assign integer_sum  = $signed(o_sum_reg);
    assign rescaled_sum = $signed(o_scaled_reg);
    assign saturated    = o_clip_reg;

endmodule

[hw/rtl/int8_quantized_dot_product.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int8_quantized_dot_product
// symmetric int8 quantized dot product with saturating 24-bit accumulator
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid / in_stall    | activation_value, weight_value, last_term
//  out     | out_valid / out_stall  | integer_sum, rescaled_sum, saturated
//  cfg     | cfg_wr_en              | cfg_index, cfg_data
//
//  one item per cycle unless stalled, set by the single int8 multiply-accumulate
//  a result passes front, queue, then product, sum, rescale and output stages
//  the front quantizes, the back accumulates; the queue lets either side stall
//  reset clears the accumulator, clip flag, queue and restores the scale registers
// ----------------------------------------------------------------------------
module int8_quantized_dot_product
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [i8dp_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [i8dp_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [31:0]                    activation_value,
    input  logic signed [31:0]                    weight_value,
    input  logic                                  last_term,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [23:0]                    integer_sum,
    output logic signed [31:0]                    rescaled_sum,
    output logic                                  saturated
);
    import i8dp_pkg::*;

    logic [15:0] inverse_scale_reg;
    logic [15:0] inverse_scale_next;
    logic [31:0] scale_squared_reg;
    logic [31:0] scale_squared_next;

    qstatus_t    q_status;
    qentry_t     q_din;
    qentry_t     q_dout;
    logic        q_push;
    logic        q_pop;

    always_comb
    begin
        inverse_scale_next = inverse_scale_reg;
        scale_squared_next = scale_squared_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_INVERSE_SCALE: inverse_scale_next = cfg_data[15:0];
                CFG_SCALE_SQUARED: scale_squared_next = cfg_data[31:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inverse_scale_reg <= INVERSE_SCALE_RESET;
            scale_squared_reg <= SCALE_SQUARED_RESET;
        end
        else
        begin
            inverse_scale_reg <= inverse_scale_next;
            scale_squared_reg <= scale_squared_next;
        end
    end

    i8dp_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .activation_value (activation_value),
        .weight_value     (weight_value),
        .last_term        (last_term),
        .inverse_scale    (inverse_scale_reg),
        .q_status         (q_status),
        .q_push           (q_push),
        .q_din            (q_din)
    );

    i8dp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .din    (q_din),
        .pop    (q_pop),
        .dout   (q_dout),
        .status (q_status)
    );

    i8dp_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .q_dout        (q_dout),
        .q_pop         (q_pop),
        .scale_squared (scale_squared_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .integer_sum   (integer_sum),
        .rescaled_sum  (rescaled_sum),
        .saturated     (saturated)
    );

endmodule
